// File: rtl/core/wfc_pkg.sv
// Shared types, constants and tables of the waypoint follow controller.
`timescale 1ns / 1ps
`default_nettype none
package wfc_pkg;

	localparam int MAX_WAYPOINTS_DEF = 8;
	localparam int CFG_AW            = 5;
	localparam int ANG_PI            = 25736;
	localparam int ANG_TWO_PI        = 51472;
	localparam int CORDIC_STEPS      = 14;
	localparam int SQRT_STEPS        = 17;

	typedef enum logic [1:0] {
		OP_POSE = 2'd0,
		OP_TICK = 2'd1,
		OP_LOAD = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_TURN     = 2'd0,
		STAT_DRIVE    = 2'd1,
		STAT_ARRIVED  = 2'd2,
		STAT_FINISHED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_COUNT     = 3'd0,
		REG_TOL       = 3'd1,
		REG_THR       = 3'd2,
		REG_ANG_GAIN  = 3'd3,
		REG_LIN_GAIN  = 3'd4,
		REG_MAX_SPEED = 3'd5,
		REG_MIN_SPEED = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_DIFF,
		S_SQX,
		S_SQY,
		S_SQRT,
		S_CHECK,
		S_CORDIC,
		S_WRAP,
		S_SCALE,
		S_FINAL,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		logic [3:0]  count;
		logic [14:0] tol;
		logic [14:0] thr;
		logic [11:0] ang_gain;
		logic [11:0] lin_gain;
		logic [14:0] max_speed;
		logic [14:0] min_speed;
	} cfg_t;

	localparam logic [3:0]  RST_COUNT     = 4'd0;
	localparam logic [14:0] RST_TOL       = 15'd41;
	localparam logic [14:0] RST_THR       = 15'd492;
	localparam logic [11:0] RST_ANG_GAIN  = 12'd896;
	localparam logic [11:0] RST_LIN_GAIN  = 12'd402;
	localparam logic [14:0] RST_MAX_SPEED = 15'd4915;
	localparam logic [14:0] RST_MIN_SPEED = 15'd205;

	function automatic logic [12:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0:    atan_lut = 13'd6434;
			4'd1:    atan_lut = 13'd3798;
			4'd2:    atan_lut = 13'd2007;
			4'd3:    atan_lut = 13'd1019;
			4'd4:    atan_lut = 13'd511;
			4'd5:    atan_lut = 13'd256;
			4'd6:    atan_lut = 13'd128;
			4'd7:    atan_lut = 13'd64;
			4'd8:    atan_lut = 13'd32;
			4'd9:    atan_lut = 13'd16;
			4'd10:   atan_lut = 13'd8;
			4'd11:   atan_lut = 13'd4;
			4'd12:   atan_lut = 13'd2;
			4'd13:   atan_lut = 13'd1;
			default: atan_lut = 13'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/waypoint_follow_controller.sv
// Top level of the waypoint follow controller: stream ports and APB port.
//
// Input stream s_*: s_tuser carries the operation (pose update, control tick,
// waypoint load, none), s_tdata the pose and waypoint fields. Pose, load and
// none items give no result. A tick gives one result item on m_*.
// A tick past the last waypoint goes straight to the emit state. Otherwise the
// tick runs a 17-step square root for the distance; a reached waypoint gives
// an arrival result, else come 14 CORDIC vectoring steps (none for a zero
// vector), a wrap that may repeat and a shared multiply for the command.
// One multiplier, the square-root step and the CORDIC step are the shared
// units; s_tready is high only between items.
// The result sits in an output register; when the receiver stalls it holds
// there, and a following tick waits at its end until the register frees.
// Reset clears pose, index, configuration and pending results; the waypoint
// table holds garbage until loaded. Configure through APB while idle.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_follow_controller
	import wfc_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [87:0]       s_tdata,  // pose_x, pose_y, pose_heading, waypoint_slot, waypoint_x, waypoint_y
	input  wire logic [1:0]        s_tuser,  // operation
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [39:0]            m_tdata,  // angular_velocity, linear_velocity, current_waypoint
	output logic [1:0]             m_tuser,  // status
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	cfg_t               cfg;
	status_t            status;
	logic signed [15:0] ang;
	logic [14:0]        lin;
	logic [3:0]         idx;

	wfc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wfc_core #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_op           (op_t'(s_tuser)),
		.in_pose_x       (s_tdata[15:0]),
		.in_pose_y       (s_tdata[31:16]),
		.in_pose_heading (s_tdata[47:32]),
		.in_slot         (s_tdata[50:48]),
		.in_wpt_x        (s_tdata[66:51]),
		.in_wpt_y        (s_tdata[82:67]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (status),
		.out_ang         (ang),
		.out_lin         (lin),
		.out_idx         (idx)
	);

	assign m_tuser = status;
	assign m_tdata = {5'd0, idx, lin, ang};

endmodule
`default_nettype wire

// File: rtl/core/wfc_cfg.sv
// Configuration register file behind the APB port.
`timescale 1ns / 1ps
`default_nettype none
module wfc_cfg
	import wfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count     <= RST_COUNT;
			cfg_q.tol       <= RST_TOL;
			cfg_q.thr       <= RST_THR;
			cfg_q.ang_gain  <= RST_ANG_GAIN;
			cfg_q.lin_gain  <= RST_LIN_GAIN;
			cfg_q.max_speed <= RST_MAX_SPEED;
			cfg_q.min_speed <= RST_MIN_SPEED;
		end else if (wr_en) begin
			unique case (idx)
				REG_COUNT:     cfg_q.count     <= pwdata[3:0];
				REG_TOL:       cfg_q.tol       <= pwdata[14:0];
				REG_THR:       cfg_q.thr       <= pwdata[14:0];
				REG_ANG_GAIN:  cfg_q.ang_gain  <= pwdata[11:0];
				REG_LIN_GAIN:  cfg_q.lin_gain  <= pwdata[11:0];
				REG_MAX_SPEED: cfg_q.max_speed <= pwdata[14:0];
				REG_MIN_SPEED: cfg_q.min_speed <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COUNT:     prdata = {28'd0, cfg_q.count};
			REG_TOL:       prdata = {17'd0, cfg_q.tol};
			REG_THR:       prdata = {17'd0, cfg_q.thr};
			REG_ANG_GAIN:  prdata = {20'd0, cfg_q.ang_gain};
			REG_LIN_GAIN:  prdata = {20'd0, cfg_q.lin_gain};
			REG_MAX_SPEED: prdata = {17'd0, cfg_q.max_speed};
			REG_MIN_SPEED: prdata = {17'd0, cfg_q.min_speed};
			default:       prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/wfc_core.sv
// Sequencer and shared multiply, square root and CORDIC datapath.
`timescale 1ns / 1ps
`default_nettype none
module wfc_core
	import wfc_pkg::*;
#(
	parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire op_t                in_op,
	input  wire logic signed [15:0] in_pose_x,
	input  wire logic signed [15:0] in_pose_y,
	input  wire logic signed [15:0] in_pose_heading,
	input  wire logic [2:0]         in_slot,
	input  wire logic signed [15:0] in_wpt_x,
	input  wire logic signed [15:0] in_wpt_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output status_t                 out_status,
	output logic signed [15:0]      out_ang,
	output logic [14:0]             out_lin,
	output logic [3:0]              out_idx
);

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

	fsm_t state_q, state_d;

	logic signed [15:0] mem_x [MAX_WAYPOINTS];
	logic signed [15:0] mem_y [MAX_WAYPOINTS];

	logic signed [15:0] sx_q, sy_q, sh_q;
	logic [3:0]         idx_q;
	logic signed [15:0] rdx_q, rdy_q;
	logic signed [16:0] dx_q, dy_q;
	logic [33:0]        acc_q;
	logic [19:0]        rem_q;
	logic [16:0]        root_q;
	logic [4:0]         cnt_q;
	logic signed [27:0] cx_q, cy_q;
	logic signed [18:0] z_q;
	logic               turn_q;
	logic signed [39:0] prod_q;

	status_t            res_status_q;
	logic signed [15:0] res_ang_q;
	logic [14:0]        res_lin_q;
	logic [3:0]         res_idx_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic signed [15:0] out_ang_q;
	logic [14:0]        out_lin_q;
	logic [3:0]         out_idx_q;

	logic               accept, finished, out_free, arrive, zero_vec, sqrt_done, cordic_done;
	logic               in_range;
	logic [31:0]        eff_count;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic signed [19:0] mul_a, mul_b;
	logic signed [39:0] mul_p;
	logic [21:0]        rem_n, trial;
	logic signed [27:0] xs, ys, xi, yi;
	logic signed [18:0] z_n, atan_v, abs_err;
	logic signed [39:0] turn_v, lin_v;

	assign accept    = in_valid & in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign eff_count = (32'(cfg.count) < MAX_WAYPOINTS) ? 32'(cfg.count) : MAX_WAYPOINTS;
	assign finished  = (32'(idx_q) >= eff_count);
	assign rd_addr   = AW'(idx_q);
	assign wr_addr   = AW'(in_slot);
	assign arrive    = (root_q < 17'(cfg.tol));
	assign zero_vec  = (dx_q == 17'sd0) && (dy_q == 17'sd0);
	assign sqrt_done   = (cnt_q == 5'(SQRT_STEPS - 1));
	assign cordic_done = (cnt_q == 5'(CORDIC_STEPS - 1));

	always_comb begin
		unique case (state_q)
			S_SQX:   begin mul_a = 20'(dx_q); mul_b = 20'(dx_q); end
			S_SQY:   begin mul_a = 20'(dy_q); mul_b = 20'(dy_q); end
			S_SCALE: begin
				if (turn_q) begin
					mul_a = 20'(z_q);
					mul_b = $signed({8'd0, cfg.ang_gain});
				end else begin
					mul_a = $signed({3'd0, root_q});
					mul_b = $signed({8'd0, cfg.lin_gain});
				end
			end
			default: begin mul_a = 20'sd0; mul_b = 20'sd0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign rem_n = {rem_q, acc_q[33:32]};
	assign trial = {3'd0, root_q, 2'b01};

	assign xi     = {{3{dx_q[16]}}, dx_q, 8'd0};
	assign yi     = {{3{dy_q[16]}}, dy_q, 8'd0};
	assign xs     = cx_q >>> cnt_q[3:0];
	assign ys     = cy_q >>> cnt_q[3:0];
	assign atan_v = $signed({6'd0, atan_lut(cnt_q[3:0])});
	assign z_n    = cy_q[27] ? (z_q - atan_v) : (z_q + atan_v);
	assign abs_err = z_q[18] ? -z_q : z_q;
	assign turn_v = (prod_q + 40'sd512) >>> 10;
	assign lin_v  = (prod_q + 40'sd128) >>> 8;
	assign in_range = (32'(in_slot) < MAX_WAYPOINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept && in_op == OP_TICK) state_d = finished ? S_EMIT : S_FETCH;
			S_FETCH:  state_d = S_DIFF;
			S_DIFF:   state_d = S_SQX;
			S_SQX:    state_d = S_SQY;
			S_SQY:    state_d = S_SQRT;
			S_SQRT:   if (sqrt_done) state_d = S_CHECK;
			S_CHECK:  state_d = arrive ? S_EMIT : (zero_vec ? S_WRAP : S_CORDIC);
			S_CORDIC: if (cordic_done) state_d = S_WRAP;
			S_WRAP:   if (z_q <= 19'(ANG_PI) && z_q >= -19'(ANG_PI)) state_d = S_SCALE;
			S_SCALE:  state_d = S_FINAL;
			S_FINAL:  state_d = S_EMIT;
			S_EMIT:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q        <= 16'sd0;
			sy_q        <= 16'sd0;
			sh_q        <= 16'sd0;
			idx_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && in_op == OP_POSE) begin
				sx_q <= in_pose_x;
				sy_q <= in_pose_y;
				sh_q <= in_pose_heading;
			end
			if (state_q == S_CHECK && arrive) idx_q <= idx_q + 4'd1;
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_op == OP_LOAD && in_range) begin
			mem_x[wr_addr] <= in_wpt_x;
			mem_y[wr_addr] <= in_wpt_y;
		end
		if (state_q == S_FETCH) begin
			rdx_q <= mem_x[rd_addr];
			rdy_q <= mem_y[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_status_q <= STAT_FINISHED;
				res_ang_q    <= 16'sd0;
				res_lin_q    <= 15'd0;
				res_idx_q    <= idx_q;
			end
			S_DIFF: begin
				dx_q <= {rdx_q[15], rdx_q} - {sx_q[15], sx_q};
				dy_q <= {rdy_q[15], rdy_q} - {sy_q[15], sy_q};
			end
			S_SQX: acc_q <= 34'(mul_p);
			S_SQY: begin
				acc_q  <= acc_q + 34'(mul_p);
				rem_q  <= 20'd0;
				root_q <= 17'd0;
				cnt_q  <= 5'd0;
			end
			S_SQRT: begin
				if (rem_n >= trial) begin
					rem_q  <= 20'(rem_n - trial);
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q  <= 20'(rem_n);
					root_q <= {root_q[15:0], 1'b0};
				end
				acc_q <= {acc_q[31:0], 2'b00};
				cnt_q <= cnt_q + 5'd1;
			end
			S_CHECK: begin
				cnt_q <= 5'd0;
				if (arrive) begin
					res_status_q <= STAT_ARRIVED;
					res_idx_q    <= idx_q + 4'd1;
				end else if (zero_vec) begin
					z_q <= -19'(sh_q);
				end else if (dx_q[16]) begin
					cx_q <= -xi;
					cy_q <= -yi;
					z_q  <= dy_q[16] ? -19'(ANG_PI) : 19'(ANG_PI);
				end else begin
					cx_q <= xi;
					cy_q <= yi;
					z_q  <= 19'sd0;
				end
			end
			S_CORDIC: begin
				if (cy_q[27]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
				end
				z_q   <= cordic_done ? (z_n - 19'(sh_q)) : z_n;
				cnt_q <= cnt_q + 5'd1;
			end
			S_WRAP: begin
				if (z_q > 19'(ANG_PI)) begin
					z_q <= z_q - 19'(ANG_TWO_PI);
				end else if (z_q < -19'(ANG_PI)) begin
					z_q <= z_q + 19'(ANG_TWO_PI);
				end else begin
					turn_q <= (abs_err > $signed({4'd0, cfg.thr}));
				end
			end
			S_SCALE: prod_q <= mul_p;
			S_FINAL: begin
				if (turn_q) begin
					res_status_q <= STAT_TURN;
					if (turn_v > 40'sd32767) begin
						res_ang_q <= 16'sd32767;
					end else if (turn_v < -40'sd32768) begin
						res_ang_q <= -16'sd32768;
					end else begin
						res_ang_q <= 16'(turn_v);
					end
				end else begin
					res_status_q <= STAT_DRIVE;
					if (lin_v < $signed({25'd0, cfg.min_speed})
						|| cfg.max_speed < cfg.min_speed) begin
						if (lin_v > $signed({25'd0, cfg.max_speed})) begin
							res_lin_q <= cfg.min_speed;
						end else if (lin_v < $signed({25'd0, cfg.min_speed})) begin
							res_lin_q <= cfg.min_speed;
						end else begin
							res_lin_q <= 15'(lin_v);
						end
					end else if (lin_v > $signed({25'd0, cfg.max_speed})) begin
						res_lin_q <= cfg.max_speed;
					end else begin
						res_lin_q <= 15'(lin_v);
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_ang_q    <= res_ang_q;
					out_lin_q    <= res_lin_q;
					out_idx_q    <= res_idx_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_ang    = out_ang_q;
	assign out_lin    = out_lin_q;
	assign out_idx    = out_idx_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("ready outside idle");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != $past(idx_q) |-> $past(state_q) == S_CHECK && $past(arrive))
		else $error("index moved without arrival");
	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == STAT_FINISHED |-> out_ang_q == 16'sd0
		&& out_lin_q == 15'd0)
		else $error("finished with nonzero velocity");
	a_drive_ang: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == STAT_DRIVE |-> out_ang_q == 16'sd0)
		else $error("driving with turn rate");

endmodule
`default_nettype wire

// File: tb/waypoint_follow_controller_tb.sv
// Self-checking testbench for the waypoint follow controller: directed and random items.
`timescale 1ns / 1ps
module waypoint_follow_controller_tb;
	import wfc_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		status_t     status;
		logic [15:0] ang;
		logic [14:0] lin;
		logic [3:0]  idx;
	} command_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	waypoint_follow_controller dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	command_t expected_cmds[$];
	int       mismatches = 0;
	int       idle_streak = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_left = 0;

	// predictor state
	longint wp_x[MAX_WAYPOINTS_DEF];
	longint wp_y[MAX_WAYPOINTS_DEF];
	int     prog_idx = 0;
	longint pos_x = 0, pos_y = 0, pos_hd = 0;
	int     wp_count = 0;
	longint tol = 41, thr = 492, ang_gain = 896, lin_gain = 402;
	longint max_spd = 4915, min_spd = 205;

	initial forever #4 clk = ~clk;

	function automatic longint int_sqrt(longint v);
		longint r, b;
		r = 0;
		b = longint'(1) << 40;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint bearing_to(longint dx, longint dy);
		longint x, y, z, xs, ys;
		longint atans[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (dx < 0) begin
			x = -x;
			y = -y;
			z = (dy >= 0) ? ANG_PI : -ANG_PI;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - atans[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + atans[i];
			end
		end
		return z;
	endfunction

	function automatic void predict_command(op_t op, logic [87:0] d);
		command_t c;
		longint dx, dy, distance, err, ang, lin;
		int cnt;
		if (op == OP_POSE) begin
			pos_x = longint'($signed(d[15:0]));
			pos_y = longint'($signed(d[31:16]));
			pos_hd = longint'($signed(d[47:32]));
			return;
		end
		if (op == OP_LOAD) begin
			wp_x[d[50:48]] = longint'($signed(d[66:51]));
			wp_y[d[50:48]] = longint'($signed(d[82:67]));
			return;
		end
		if (op != OP_TICK) return;
		ang = 0;
		lin = 0;
		cnt = (wp_count < MAX_WAYPOINTS_DEF) ? wp_count : MAX_WAYPOINTS_DEF;
		if (prog_idx >= cnt) begin
			c.status = STAT_FINISHED;
		end else begin
			dx = wp_x[prog_idx] - pos_x;
			dy = wp_y[prog_idx] - pos_y;
			distance = int_sqrt(dx * dx + dy * dy);
			if (distance < tol) begin
				prog_idx++;
				c.status = STAT_ARRIVED;
			end else begin
				err = bearing_to(dx, dy) - pos_hd;
				while (err > ANG_PI) err = err - ANG_TWO_PI;
				while (err < -ANG_PI) err = err + ANG_TWO_PI;
				if ((err < 0 ? -err : err) > thr) begin
					ang = (err * ang_gain + 512) >>> 10;
					if (ang > 32767) ang = 32767;
					if (ang < -32768) ang = -32768;
					c.status = STAT_TURN;
				end else begin
					lin = (distance * lin_gain + 128) >> 8;
					if (lin > max_spd) lin = max_spd;
					if (lin < min_spd) lin = min_spd;
					c.status = STAT_DRIVE;
				end
			end
		end
		c.ang = ang[15:0];
		c.lin = lin[14:0];
		c.idx = prog_idx[3:0];
		expected_cmds.push_back(c);
	endfunction

	// receiver side: drive tready at the falling edge
	initial forever begin
		@(negedge clk);
		if (hold_left > 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial forever begin
		command_t c;
		@(posedge clk);
		if (m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected result status=%0d data=%h", $time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				c = expected_cmds.pop_front();
				if (m_tuser !== c.status) begin
					$display("%0t: status expected %0d actual %0d", $time, c.status, m_tuser);
					mismatches++;
				end
				if (m_tdata[15:0] !== c.ang) begin
					$display("%0t: angular expected %0d actual %0d", $time,
						$signed(c.ang), $signed(m_tdata[15:0]));
					mismatches++;
				end
				if (m_tdata[30:16] !== c.lin) begin
					$display("%0t: linear expected %0d actual %0d", $time, c.lin, m_tdata[30:16]);
					mismatches++;
				end
				if (m_tdata[34:31] !== c.idx) begin
					$display("%0t: index expected %0d actual %0d", $time, c.idx, m_tdata[34:31]);
					mismatches++;
				end
			end
		end
	end

	initial forever begin
		@(posedge clk);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_streak = 0;
		else
			idle_streak++;
	end

	task automatic send_item(op_t op, logic [15:0] px, logic [15:0] py, logic [15:0] hd,
			logic [2:0] slot, logic [15:0] wx, logic [15:0] wy);
		if ($urandom_range(0, 99) < send_idle_pct)
			repeat ($urandom_range(1, 3)) @(negedge clk);
		s_tuser = op;
		s_tdata = {5'd0, wy, wx, slot, hd, py, px};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_command(op, s_tdata);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_pose(longint x, longint y, longint hd);
		send_item(OP_POSE, x[15:0], y[15:0], hd[15:0], 3'($urandom), 16'($urandom),
			16'($urandom));
	endtask

	task automatic send_load(int slot, longint x, longint y);
		send_item(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), slot[2:0], x[15:0],
			y[15:0]);
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic write_reg(reg_idx_t r, int value);
		wait (expected_cmds.size() == 0);
		repeat (60) @(posedge clk);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {r, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (r)
			REG_COUNT:     wp_count = value & 'hF;
			REG_TOL:       tol = value & 'h7FFF;
			REG_THR:       thr = value & 'h7FFF;
			REG_ANG_GAIN:  ang_gain = value & 'hFFF;
			REG_LIN_GAIN:  lin_gain = value & 'hFFF;
			REG_MAX_SPEED: max_spd = value & 'h7FFF;
			REG_MIN_SPEED: min_spd = value & 'h7FFF;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	function automatic longint wrap_angle(longint a);
		while (a > ANG_PI) a = a - ANG_TWO_PI;
		while (a < -ANG_PI) a = a + ANG_TWO_PI;
		return a;
	endfunction

	task automatic test_finished_at_start();
		send_tick();
		send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < MAX_WAYPOINTS_DEF; i++)
			send_load(i, longint'($urandom_range(0, 4000)) - 2000,
				longint'($urandom_range(0, 4000)) - 2000);
		write_reg(REG_COUNT, 8);
	endtask

	task automatic test_arrival();
		send_pose(wp_x[0] + 10, wp_y[0] - 10, 0);
		send_tick();
		send_tick();
	endtask

	task automatic test_zero_vector();
		write_reg(REG_TOL, 0);
		send_pose(wp_x[1], wp_y[1], 0);
		send_tick();
		send_pose(wp_x[1], wp_y[1], 5000);
		send_tick();
		write_reg(REG_TOL, 41);
	endtask

	task automatic test_extremes();
		write_reg(REG_ANG_GAIN, 4095);
		write_reg(REG_THR, 0);
		send_load(1, 32767, 32767);
		send_pose(-32768, -32768, -25736);
		send_tick();
		send_pose(32767, -32768, 25736);
		send_tick();
		send_load(1, -32768, 0);
		send_pose(32767, 0, 0);
		send_tick();
		write_reg(REG_THR, 25736);
		write_reg(REG_LIN_GAIN, 4095);
		write_reg(REG_MAX_SPEED, 32767);
		send_tick();
		write_reg(REG_LIN_GAIN, 0);
		write_reg(REG_MIN_SPEED, 0);
		send_tick();
		write_reg(REG_MIN_SPEED, 32767);
		write_reg(REG_MAX_SPEED, 0);
		send_tick();
		write_reg(REG_ANG_GAIN, 0);
		write_reg(REG_THR, 0);
		send_pose(32767, 100, 12000);
		send_tick();
		write_reg(REG_ANG_GAIN, 896);
		write_reg(REG_THR, 492);
		write_reg(REG_LIN_GAIN, 402);
		write_reg(REG_MAX_SPEED, 4915);
		write_reg(REG_MIN_SPEED, 205);
	endtask

	task automatic test_random_traffic(int n);
		longint x, y, hd;
		int r, s;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			s = (prog_idx < MAX_WAYPOINTS_DEF) ? prog_idx : 0;
			if (r < 5) begin
				send_item(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom),
					16'($urandom), 16'($urandom));
			end else if (r < 15) begin
				send_load($urandom_range(0, 7), longint'($urandom_range(0, 65535)) - 32768,
					longint'($urandom_range(0, 65535)) - 32768);
			end else if (r < 45) begin
				if ($urandom_range(0, 99) < 2) begin
					x = wp_x[s] + longint'($urandom_range(0, 40)) - 20;
					y = wp_y[s] + longint'($urandom_range(0, 40)) - 20;
				end else begin
					x = longint'($urandom_range(0, 65535)) - 32768;
					y = longint'($urandom_range(0, 65535)) - 32768;
				end
				if ($urandom_range(0, 1)) begin
					hd = wrap_angle(bearing_to(wp_x[s] - x, wp_y[s] - y) +
						longint'($urandom_range(0, 1200)) - 600);
				end else begin
					hd = longint'($urandom_range(0, ANG_TWO_PI)) - ANG_PI;
				end
				send_pose(x, y, hd);
			end else begin
				send_tick();
			end
		end
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		for (int k = 0; k < 12; k++) begin
			send_pose(longint'($urandom_range(0, 65535)) - 32768,
				longint'($urandom_range(0, 65535)) - 32768,
				longint'($urandom_range(0, ANG_TWO_PI)) - ANG_PI);
			send_tick();
		end
	endtask

	task automatic test_index_past_count();
		write_reg(REG_TOL, 32767);
		send_pose(wp_x[prog_idx % 8], wp_y[prog_idx % 8], 0);
		send_tick();
		send_tick();
		write_reg(REG_COUNT, (prog_idx > 0) ? prog_idx - 1 : 0);
		send_tick();
		send_tick();
		write_reg(REG_COUNT, 15);
		send_tick();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_finished_at_start();
		test_arrival();
		test_zero_vector();
		test_extremes();
		test_random_traffic(260);
		send_idle_pct = 46;
		test_random_traffic(260);
		write_reg(REG_THR, 2000);
		write_reg(REG_ANG_GAIN, 4095);
		send_idle_pct = 0;
		recv_stall_pct = 46;
		test_random_traffic(260);
		write_reg(REG_LIN_GAIN, 4095);
		write_reg(REG_MAX_SPEED, 32767);
		write_reg(REG_TOL, 300);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		test_random_traffic(240);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		test_index_past_count();
		wait (expected_cmds.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		while (idle_streak < STALL_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

endmodule
